### design/plist_pkg.sv
// Package for the positional list engine: sizes, operation and status codes,
// and the control struct passed from the decoder to the cell array.
// Depends on nothing; every other design file imports it.
`default_nettype none

package plist_pkg;

  // List capacity. Field widths are fixed, so the capacity is fixed as well.
  localparam int Depth  = 16;
  localparam int IdxW   = $clog2(Depth);
  localparam int FillW  = $clog2(Depth + 1);
  localparam int OpW    = 3;
  localparam int PosW   = 5;
  localparam int DataW  = 32;
  localparam int StatW  = 2;

  typedef enum logic [OpW-1:0] {
    OpInsHead = 3'd0,
    OpInsPos  = 3'd1,
    OpInsTail = 3'd2,
    OpRemHead = 3'd3,
    OpRemPos  = 3'd4,
    OpRemTail = 3'd5
  } op_e;

  typedef enum logic [StatW-1:0] {
    StOk     = 2'd0,
    StEmpty  = 2'd1,
    StFull   = 2'd2,
    StBadPos = 2'd3
  } status_e;

  // Decision for one item: open a gap or close one at idx, and its status.
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [IdxW-1:0] idx;
    status_e         status;
  } plist_ctl_t;

endpackage

`default_nettype wire

### design/plist_if.sv
// Valid/ready channel interfaces for the request and the response items.
// Depends on plist_pkg for the payload widths.
`default_nettype none

interface plist_req_if
  import plist_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [OpW-1:0]          opcode;
  logic [PosW-1:0]         position;
  logic signed [DataW-1:0] value;

  modport source (output valid, output opcode, output position, output value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input value,
                  output ready);
endinterface

interface plist_rsp_if
  import plist_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [StatW-1:0]        status;
  logic signed [DataW-1:0] removed_value;
  logic [FillW-1:0]        count;

  modport source (output valid, output status, output removed_value, output count,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input count,
                  output ready);
endinterface

`default_nettype wire

### design/positional_list_engine_top.sv
// Positional list engine top level: ordered list of signed 32-bit values
// with insert and remove at the head, a position or the tail.
// Each accepted item waits in the input stage; its result is registered.
// Throughput: one item per cycle while the response channel takes items,
// as the decode and cell shift are combinational. Reset clears the fill
// count and the channel valids; cell contents are undefined until written.
// Depends on plist_pkg, plist_if, plist_ctrl and plist_cells.
`default_nettype none

module positional_list_engine_top
  import plist_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  plist_req_if.sink    req_i,
  plist_rsp_if.source  rsp_o
);

  // Input stage: the accepted item waits here until the output register
  // has room. The list state is updated in the same cycle that the result
  // is captured, so a following item always sees the new fill count.
  logic                    s1_valid_q;
  logic [OpW-1:0]          s1_opcode_q;
  logic [PosW-1:0]         s1_position_q;
  logic signed [DataW-1:0] s1_value_q;

  // Output register decouples the two channels.
  logic                    out_valid_q;
  status_e                 out_status_q;
  logic signed [DataW-1:0] out_removed_q;
  logic [FillW-1:0]        out_count_q;

  logic                    exec;
  plist_ctl_t              ctl;
  logic [FillW-1:0]        count_new;
  logic signed [DataW-1:0] rd_data;

  // The held item executes whenever the output register is empty or drains.
  assign exec        = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_opcode_q   <= req_i.opcode;
      s1_position_q <= req_i.position;
      s1_value_q    <= req_i.value;
    end
  end

  plist_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (exec),
    .opcode_i   (s1_opcode_q),
    .position_i (s1_position_q),
    .ctl_o      (ctl),
    .count_o    (count_new)
  );

  plist_cells u_cells (
    .clk_i     (clk_i),
    .en_i      (exec),
    .ctl_i     (ctl),
    .value_i   (s1_value_q),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // A failed or ignored operation reports zero as the removed value.
  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_status_q  <= ctl.status;
      out_removed_q <= ctl.rem ? rd_data : '0;
      out_count_q   <= count_new;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.removed_value = out_removed_q;
  assign rsp_o.count         = out_count_q;

  // The reported count never exceeds the list capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_count_q <= FillW'(Depth))
    else $error("count above capacity");

  // Only a successful operation can report a removed value.
  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != StOk) |-> out_removed_q == '0)
    else $error("removed value on failed operation");

  // A held item that cannot execute stays in the input stage.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !exec) |=> s1_valid_q)
    else $error("held item lost");

  // An insert and a remove never happen for the same item.
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |-> !(ctl.ins && ctl.rem))
    else $error("insert and remove together");

endmodule

`default_nettype wire

### design/plist_ctrl.sv
// Fill counter and operation decoder of the positional list engine.
// Depends on plist_pkg.
`default_nettype none

module plist_ctrl
  import plist_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [OpW-1:0]   opcode_i,
  input  wire logic [PosW-1:0]  position_i,
  output plist_ctl_t            ctl_o,
  output logic [FillW-1:0]      count_o
);

  logic [FillW-1:0] fill_q, fill_d;
  logic             full, empty;
  logic [PosW:0]    pos_x;
  logic [PosW:0]    fill_x;
  logic [IdxW-1:0]  pos_idx;

  assign full    = (fill_q == FillW'(Depth));
  assign empty   = (fill_q == '0);
  assign pos_x   = {1'b0, position_i};
  assign fill_x  = (PosW + 1)'(fill_q);
  assign pos_idx = IdxW'(position_i - PosW'(1));

  always_comb begin
    ctl_o = '{ins: 1'b0, rem: 1'b0, idx: '0, status: StOk};
    unique case (op_e'(opcode_i))
      OpInsHead, OpInsPos, OpInsTail: begin
        if (full) begin
          ctl_o.status = StFull;
        end else if (op_e'(opcode_i) == OpInsHead) begin
          ctl_o.ins = 1'b1;
        end else if (op_e'(opcode_i) == OpInsTail || empty) begin
          ctl_o.ins = 1'b1;
          ctl_o.idx = IdxW'(fill_q);
        end else if (position_i != '0 && pos_x <= fill_x + (PosW + 1)'(1)) begin
          ctl_o.ins = 1'b1;
          ctl_o.idx = pos_idx;
        end else begin
          ctl_o.status = StBadPos;
        end
      end
      OpRemHead, OpRemPos, OpRemTail: begin
        if (empty) begin
          ctl_o.status = StEmpty;
        end else if (op_e'(opcode_i) == OpRemHead) begin
          ctl_o.rem = 1'b1;
        end else if (op_e'(opcode_i) == OpRemTail) begin
          ctl_o.rem = 1'b1;
          ctl_o.idx = IdxW'(fill_q - FillW'(1));
        end else if (position_i != '0 && pos_x <= fill_x) begin
          ctl_o.rem = 1'b1;
          ctl_o.idx = pos_idx;
        end else begin
          ctl_o.status = StBadPos;
        end
      end
      default: begin
        // Codes six and seven leave the list untouched.
      end
    endcase
  end

  always_comb begin
    fill_d = fill_q;
    if (ctl_o.ins) begin
      fill_d = fill_q + FillW'(1);
    end else if (ctl_o.rem) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  assign count_o = fill_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (en_i) begin
      fill_q <= fill_d;
    end
  end

endmodule

`default_nettype wire

### design/plist_cells.sv
// Cell array of the positional list engine: cells past the decoded index (on
// a remove, from it on) shift one place toward the tail or the head in parallel. Depends on plist_pkg.
`default_nettype none

module plist_cells
  import plist_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire plist_ctl_t              ctl_i,
  input  wire logic signed [DataW-1:0] value_i,
  output logic signed [DataW-1:0]      rd_data_o
);

  logic [DataW-1:0] cells_q [Depth];
  logic [DataW-1:0] cells_d [Depth];

  // The cell at the decoded index, read before the shift.
  assign rd_data_o = cells_q[ctl_i.idx];

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    always_comb begin
      cells_d[g] = cells_q[g];
      if (ctl_i.ins) begin
        if (ctl_i.idx == IdxW'(g)) begin
          cells_d[g] = value_i;
        end else if (ctl_i.idx < IdxW'(g)) begin
          cells_d[g] = cells_q[(g > 0) ? g - 1 : 0];
        end
      end else if (ctl_i.rem) begin
        if (ctl_i.idx <= IdxW'(g)) begin
          cells_d[g] = cells_q[(g < Depth - 1) ? g + 1 : g];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cells_q[g] <= cells_d[g];
      end
    end
  end

endmodule

`default_nettype wire

### dv/tb_positional_list_engine_top.sv
// Self-checking testbench for positional_list_engine_top: directed and random operations.
// An in-bench list predictor checks every response item against its expected result.
// Depends on plist_pkg, plist_if and the design top level.
`default_nettype none

module tb_positional_list_engine_top
  import plist_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes six and seven are not decoded by the block; it must ignore them.
  localparam logic [OpW-1:0] OpUndefLo = 3'd6;
  localparam logic [OpW-1:0] OpUndefHi = 3'd7;

  localparam int RandomItems = 1550;
  localparam int ResetCycles = 12;
  localparam int DrainCycles = 8;
  localparam int ReportLimit = 10;
  // Slowest correct run is roughly 1600 items, each slowed by a sender gap, a
  // receiver stall and the pipeline; the limit leaves a wide margin above that.
  localparam int CycleLimit  = 300000;

  typedef enum int {SeqFill, SeqDrain, SeqGrow, SeqShrink, SeqChurn, SeqNoise} seq_mode_e;

  typedef struct {
    logic [OpW-1:0]          op;
    logic [PosW-1:0]         pos;
    logic signed [DataW-1:0] value;
  } list_req_t;

  typedef struct {
    status_e                 status;
    logic signed [DataW-1:0] removed;
    logic [FillW-1:0]        count;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_n;

  plist_req_if req_if ();
  plist_rsp_if rsp_if ();

  positional_list_engine_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the list, updated once per accepted request item.
  logic signed [DataW-1:0] shadow_list [Depth];
  int                      list_fill = 0;
  int                      peak_fill = 0;

  list_req_t    pending_reqs[$];
  list_result_t expected_results[$];

  int items_queued    = 0;
  int ignored_queued  = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int cycle_count     = 0;
  int status_tally [4] = '{default: 0};

  // Sender pacing: a burst of back-to-back items, then a gap of idle cycles.
  int burst_left = 0;
  int gap_left   = 0;

  // Receiver pacing: ready follows a rotating 16-bit pattern that is replaced
  // when its hold count runs out. Bit 0 of a new pattern is always set, so no
  // stall lasts a full turn of the pattern.
  logic [15:0] ready_pattern = 16'hFFFF;
  int          pattern_hold  = 0;

  // Applies one operation to the shadow list and returns the response item it
  // should produce. Full and empty are decided before the position is looked at.
  function automatic list_result_t apply_list_op(list_req_t rq);
    list_result_t res;
    int           slot;
    int           i;
    slot        = -1;
    res.status  = StOk;
    res.removed = '0;
    case (rq.op)
      OpInsHead, OpInsPos, OpInsTail: begin
        if (list_fill >= Depth) begin
          res.status = StFull;
        end else if (rq.op == OpInsHead) begin
          slot = 0;
        end else if (rq.op == OpInsTail || list_fill == 0) begin
          // An empty list takes a positional insert at any position.
          slot = list_fill;
        end else if (rq.pos >= 1 && rq.pos <= list_fill + 1) begin
          slot = rq.pos - 1;
        end else begin
          res.status = StBadPos;
        end
        if (slot >= 0) begin
          for (i = list_fill; i > slot; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[slot] = rq.value;
          list_fill++;
        end
      end
      OpRemHead, OpRemPos, OpRemTail: begin
        if (list_fill == 0) begin
          res.status = StEmpty;
        end else if (rq.op == OpRemHead) begin
          slot = 0;
        end else if (rq.op == OpRemTail) begin
          slot = list_fill - 1;
        end else if (rq.pos >= 1 && rq.pos <= list_fill) begin
          slot = rq.pos - 1;
        end else begin
          res.status = StBadPos;
        end
        if (slot >= 0) begin
          res.removed = shadow_list[slot];
          for (i = slot; i < list_fill - 1; i++) shadow_list[i] = shadow_list[i+1];
          list_fill--;
        end
      end
      default: begin
        // Undefined opcodes leave the list alone and report ok.
      end
    endcase
    if (list_fill > peak_fill) peak_fill = list_fill;
    res.count = FillW'(list_fill);
    return res;
  endfunction

  function automatic void flag_mismatch(string what, logic [DataW-1:0] want,
                                        logic [DataW-1:0] got);
    mismatches++;
    if (mismatches <= ReportLimit)
      $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $realtime, what, want, got);
  endfunction

  // Values lean toward the two extremes, zero and minus one now and then.
  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Hands one request item to the driver. The queue is kept short so that the
  // generator can read an almost current fill level when it shapes positions.
  task automatic queue_item(input logic [OpW-1:0] op, input logic [PosW-1:0] pos,
                            input logic signed [DataW-1:0] value);
    list_req_t rq;
    while (pending_reqs.size() >= 2) @(negedge clk_i);
    rq.op    = op;
    rq.pos   = pos;
    rq.value = value;
    pending_reqs.push_back(rq);
    if (op <= OpRemTail) items_queued++;
    else ignored_queued++;
  endtask

  // Emits a run of items shaped by the mode. Apart from noise runs, positions
  // are picked inside the valid range for the current fill, and about one item
  // in ten is deliberately broken: position zero, a position past the end, or
  // an undefined opcode.
  task automatic run_sequence(input seq_mode_e mode, input int len);
    int             k;
    int             est;
    int             top;
    int             lo;
    logic           ins;
    logic [OpW-1:0] op;
    int             pos;
    for (k = 0; k < len; k++) begin
      est = list_fill;
      if (mode == SeqNoise) begin
        op  = OpW'($urandom_range(OpInsHead, OpUndefHi));
        pos = $urandom_range(0, Depth);
      end else begin
        case (mode)
          SeqFill:   ins = 1'b1;
          SeqDrain:  ins = 1'b0;
          SeqGrow:   ins = ($urandom_range(0, 4) != 0);
          SeqShrink: ins = ($urandom_range(0, 4) == 0);
          default:   ins = 1'($urandom_range(0, 1));
        endcase
        if (ins) op = OpW'($urandom_range(OpInsHead, OpInsTail));
        else op = OpW'($urandom_range(OpRemHead, OpRemTail));
        top = ins ? est + 1 : est;
        if (top < 1) top = 1;
        if (top > Depth) top = Depth;
        pos = $urandom_range(1, top);
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0: pos = 0;
            1: begin
              lo  = (top < Depth) ? top + 1 : Depth;
              pos = $urandom_range(lo, Depth);
            end
            default: op = OpW'($urandom_range(OpUndefLo, OpUndefHi));
          endcase
        end
      end
      queue_item(op, PosW'(pos), pick_value());
    end
  endtask

  // Request driver. On acceptance the item is run through the predictor and
  // its expected response is queued. A new item is presented only once the
  // previous one has been taken, so valid never drops while an item waits.
  always @(posedge clk_i) begin : req_driver
    logic holding;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      holding = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        expected_results.push_back(apply_list_op(pending_reqs.pop_front()));
        holding = 1'b0;
        if (burst_left > 0) burst_left--;
      end
      if (!holding) begin
        if (burst_left == 0) begin
          // A third of the bursts are long stretches with no idle cycles.
          if ($urandom_range(0, 2) == 0) begin
            burst_left = $urandom_range(30, 80);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 8);
          end
        end
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_if.valid    <= 1'b1;
          req_if.opcode   <= pending_reqs[0].op;
          req_if.position <= pending_reqs[0].pos;
          req_if.value    <= pending_reqs[0].value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and ready pattern. Each accepted response item is
  // compared field by field with the oldest expected result.
  always @(posedge clk_i) begin : rsp_monitor
    list_result_t want;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("unrequested response", '0, rsp_if.removed_value);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          status_tally[want.status]++;
          if (rsp_if.status !== want.status)
            flag_mismatch("status", DataW'(want.status), DataW'(rsp_if.status));
          if (rsp_if.removed_value !== want.removed)
            flag_mismatch("removed_value", want.removed, rsp_if.removed_value);
          if (rsp_if.count !== want.count)
            flag_mismatch("count", DataW'(want.count), DataW'(rsp_if.count));
        end
      end
      if (pattern_hold == 0) begin
        pattern_hold = $urandom_range(64, 400);
        if ($urandom_range(0, 3) == 0) ready_pattern = 16'hFFFF;
        else ready_pattern = 16'($urandom()) | 16'h0001;
      end else begin
        pattern_hold--;
      end
      rsp_if.ready  <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int target;
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.opcode   = OpInsHead;
    req_if.position = '0;
    req_if.value    = '0;
    rsp_if.ready    = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed part. Removes from an empty list report empty whatever the
    // position says.
    queue_item(OpRemHead, 5'd0, 32'h1234_5678);
    queue_item(OpRemPos, 5'd0, '0);
    queue_item(OpRemTail, 5'd16, '0);
    // A positional insert into an empty list takes even an absurd position.
    queue_item(OpInsPos, 5'd16, 32'h7FFF_FFFF);
    queue_item(OpInsHead, 5'd0, 32'h8000_0000);
    queue_item(OpInsTail, 5'd31, 32'hFFFF_FFFF);
    // Three elements held: position zero and fill plus two are rejected,
    // fill plus one appends and one goes to the head.
    queue_item(OpInsPos, 5'd0, 32'h0BAD_0000);
    queue_item(OpInsPos, 5'd5, 32'h0BAD_0001);
    queue_item(OpInsPos, 5'd4, 32'h0000_0004);
    queue_item(OpInsPos, 5'd1, 32'h0000_0001);
    // Undefined opcodes are ignored.
    queue_item(OpUndefLo, 5'd1, 32'hDEAD_BEEF);
    queue_item(OpUndefHi, 5'd15, 32'h5555_AAAA);
    // Five elements held: remove at position zero and fill plus one fail,
    // then every remove flavor empties the list again.
    queue_item(OpRemPos, 5'd0, '0);
    queue_item(OpRemPos, 5'd6, '0);
    queue_item(OpRemPos, 5'd5, '0);
    queue_item(OpRemPos, 5'd1, '0);
    queue_item(OpRemHead, 5'd3, '0);
    queue_item(OpRemTail, 5'd0, '0);
    queue_item(OpRemTail, 5'd1, '0);

    // The random part opens with a fill run long enough to hit a full list
    // and try every insert flavor on it.
    target = items_queued + RandomItems;
    run_sequence(SeqFill, 22);
    while (items_queued < target) begin
      case ($urandom_range(0, 9))
        0:       run_sequence(SeqFill, $urandom_range(10, 24));
        1:       run_sequence(SeqDrain, $urandom_range(10, 24));
        2, 3:    run_sequence(SeqGrow, $urandom_range(4, 40));
        4, 5:    run_sequence(SeqShrink, $urandom_range(4, 40));
        6, 7, 8: run_sequence(SeqChurn, $urandom_range(4, 40));
        default: run_sequence(SeqNoise, $urandom_range(4, 20));
      endcase
    end

    while (pending_reqs.size() != 0) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    // A drain period at the end catches any stray response after the last one.
    repeat (DrainCycles) @(negedge clk_i);

    $display("Ran %0d list operations plus %0d undefined opcodes.",
             items_queued, ignored_queued);
    $display("%0d responses checked, peak fill %0d of %0d.",
             results_checked, peak_fill, Depth);
    $display("Status mix: ok %0d, empty %0d, full %0d, bad position %0d; %0d mismatches.",
             status_tally[StOk], status_tally[StEmpty], status_tally[StFull],
             status_tally[StBadPos], mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
